FILE: hdl/ife_pkg.sv
// ----------------------------------------------------------------------------
// ife_pkg
// Shared types and constants for the ISO14443A frame encoder.
// ----------------------------------------------------------------------------
package ife_pkg;

  localparam int CODE_W    = 4;
  localparam int MAX_CODES = 10;
  localparam int WORD_W    = CODE_W * MAX_CODES;
  localparam int NB_W      = 3;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [CODE_W-1:0] MILLER_ONE         = 4'b1101;
  localparam logic [CODE_W-1:0] MILLER_ZERO_AFT_Z  = 4'b0111;
  localparam logic [CODE_W-1:0] MILLER_ZERO_AFT_O  = 4'b1111;
  localparam logic [CODE_W-1:0] MANCH_ONE          = 4'b1100;
  localparam logic [CODE_W-1:0] MANCH_ZERO         = 4'b0011;

  localparam logic [CODE_W-1:0] READER_START_RST = 4'd7;
  localparam logic [CODE_W-1:0] CARD_START_RST   = 4'd12;
  localparam logic [CODE_W-1:0] CARD_END_RST     = 4'd0;

  localparam logic [3:0] MAX_BITS = 4'd8;

  typedef enum logic [1:0] {
    CFG_CARD_MODE    = 2'd0,
    CFG_READER_START = 2'd1,
    CFG_CARD_START   = 2'd2,
    CFG_CARD_END     = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic              card_mode;
    logic [CODE_W-1:0] reader_start;
    logic [CODE_W-1:0] card_start;
    logic [CODE_W-1:0] card_end;
  } cfg_t;

  // One accepted item, already coded and packed into output bytes.
  typedef struct packed {
    logic [WORD_W-1:0] bytes;
    logic [NB_W-1:0]   nbytes;
    logic              half;
    logic              is_end;
  } job_t;

endpackage

FILE: hdl/ife_front.sv
// ----------------------------------------------------------------------------
// ife_front
// Codes one input item into line codes and packs them into output bytes,
// keeping the previous bit and the held nibble across items.
// ----------------------------------------------------------------------------
module ife_front import ife_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        accept,
  input  logic [7:0]  data_bits,
  input  logic [3:0]  bit_count,
  input  logic        frame_start,
  input  logic        frame_end,
  output job_t        job,
  output logic        push
);

  logic              prev_r, prev_nxt;
  logic [CODE_W-1:0] held_nib_r, held_nib_nxt;
  logic              held_vld_r, held_vld_nxt;

  logic [3:0]        cnt;
  logic              prev0;
  logic              prev_after;
  logic              np;
  logic [CODE_W-1:0] pre;
  logic [CODE_W-1:0] end_code;
  logic [31:0]       data_word;
  logic [WORD_W-1:0] word;
  logic [WORD_W-1:0] tail;
  logic [3:0]        pos;
  logic [3:0]        len;
  logic [NB_W-1:0]   nb;

  always_comb begin
    logic              chain;
    logic              dbit;
    logic [CODE_W-1:0] code;

    cnt   = (bit_count > MAX_BITS) ? MAX_BITS : bit_count;
    prev0 = frame_start ? 1'b0 : prev_r;
    np    = frame_start | held_vld_r;
    pre   = frame_start ? (cfg.card_mode ? cfg.card_start : cfg.reader_start)
                        : held_nib_r;

    data_word = '0;
    chain     = prev0;
    for (int i = 0; i < 8; i++) begin
      dbit = data_bits[7-i];
      if (cfg.card_mode) begin
        code = dbit ? MANCH_ONE : MANCH_ZERO;
      end else begin
        code = dbit ? MILLER_ONE : (chain ? MILLER_ZERO_AFT_O : MILLER_ZERO_AFT_Z);
      end
      if (i < cnt) begin
        data_word[31-4*i -: 4] = code;
      end
      chain = dbit;
    end

    prev_after = (cnt == 4'd0) ? prev0 : data_bits[3'(MAX_BITS - cnt)];
    end_code   = cfg.card_mode ? cfg.card_end
                               : (prev_after ? MILLER_ZERO_AFT_O : MILLER_ZERO_AFT_Z);

    // Codes are laid out from the top of the word in transmit order.
    word = np ? ({pre, 36'd0} | ({data_word, 8'd0} >> CODE_W)) : {data_word, 8'd0};
    pos  = {3'd0, np} + cnt;
    if (frame_end) begin
      word = word | ({end_code, 36'd0} >> {pos, 2'b00});
    end
    len  = pos + {3'd0, frame_end};
    nb   = frame_end ? NB_W'((len + 4'd1) >> 1) : NB_W'(len >> 1);
    tail = word << {len - 4'd1, 2'b00};

    job.bytes  = word;
    job.nbytes = nb;
    job.half   = frame_end & len[0];
    job.is_end = frame_end;
    push       = accept && (nb != '0);

    if (frame_end) begin
      prev_nxt     = 1'b0;
      held_vld_nxt = 1'b0;
      held_nib_nxt = '0;
    end else begin
      prev_nxt     = prev_after;
      held_vld_nxt = len[0];
      held_nib_nxt = len[0] ? tail[WORD_W-1 -: CODE_W] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r     <= 1'b0;
      held_vld_r <= 1'b0;
      held_nib_r <= '0;
    end else if (accept) begin
      prev_r     <= prev_nxt;
      held_vld_r <= held_vld_nxt;
      held_nib_r <= held_nib_nxt;
    end
  end

endmodule

FILE: hdl/ife_queue.sv
// ----------------------------------------------------------------------------
// ife_queue
// Small job queue between the coding front and the byte serializer.
// ----------------------------------------------------------------------------
module ife_queue import ife_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t wr_job,
  input  logic pop,
  output job_t rd_job,
  output logic rd_valid,
  output logic full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  assign rd_job   = mem_r[rd_ptr_r];
  assign rd_valid = (cnt_r != '0);
  assign full     = (cnt_r == CNT_W'(DEPTH));

`ifndef SYNTH
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full && !pop |-> !push)
    else $error("job written into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> rd_valid)
    else $error("job read from an empty queue");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("queue fill count out of range");
`endif

endmodule

FILE: hdl/ife_back.sv
// ----------------------------------------------------------------------------
// ife_back
// Walks the head job one byte per cycle, while the output is not stalled, into the registered output stage.
// ----------------------------------------------------------------------------
module ife_back import ife_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  job_t       rd_job,
  input  logic       rd_valid,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_coded_byte,
  output logic [1:0] out_nibble_count,
  output logic       out_last_out
);

  logic [NB_W-1:0]   idx_r, idx_nxt;
  logic              vld_r, vld_nxt;
  logic [7:0]        byte_r, byte_nxt;
  logic [1:0]        ncnt_r, ncnt_nxt;
  logic              last_r, last_nxt;
  logic              load;
  logic              last_byte;
  logic [WORD_W-1:0] shifted;

  always_comb begin
    load      = rd_valid && (!vld_r || !out_stall);
    last_byte = (idx_r == rd_job.nbytes - 1'b1);
    shifted   = rd_job.bytes << {idx_r, 3'b000};
    pop       = load && last_byte;

    idx_nxt  = idx_r;
    vld_nxt  = vld_r && out_stall;
    byte_nxt = byte_r;
    ncnt_nxt = ncnt_r;
    last_nxt = last_r;
    if (load) begin
      idx_nxt  = last_byte ? '0 : idx_r + 1'b1;
      vld_nxt  = 1'b1;
      byte_nxt = shifted[WORD_W-1 -: 8];
      ncnt_nxt = (last_byte && rd_job.half) ? 2'd1 : 2'd2;
      last_nxt = last_byte && rd_job.is_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    ncnt_r <= ncnt_nxt;
    last_r <= last_nxt;
  end

  assign out_valid        = vld_r;
  assign out_coded_byte   = byte_r;
  assign out_nibble_count = ncnt_r;
  assign out_last_out     = last_r;

`ifndef SYNTH
  a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
    rd_valid |-> (idx_r < rd_job.nbytes))
    else $error("byte index runs past the head job");

  a_half_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r && (ncnt_r == 2'd1) |-> last_r && (byte_r[3:0] == 4'd0))
    else $error("half byte that does not close a frame");

  a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !rd_valid |-> (idx_r == '0))
    else $error("byte index left over with no job queued");
`endif

endmodule

FILE: hdl/iso14443a_frame_encoder.sv
// A result byte goes through the job queue, then the registered output stage.
// The serializer sends one byte per cycle while out_stall is low; an item
// yields up to five bytes (four for a full data byte).
// The front takes a new item every cycle while the job queue has room.
// Reset (rst_n low, synchronous) empties the queue and output stage and
// restores the register reset values and the frame state.
// ----------------------------------------------------------------------------
// iso14443a_frame_encoder
// Modified Miller / Manchester frame encoder with nibble packing.
// ----------------------------------------------------------------------------
module iso14443a_frame_encoder import ife_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_bits,
  input  logic [3:0] in_bit_count,
  input  logic       in_frame_start,
  input  logic       in_frame_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_coded_byte,
  output logic [1:0] out_nibble_count,
  output logic       out_last_out,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [3:0] cfg_data
);

  cfg_t cfg_r, cfg_nxt;
  job_t wr_job, rd_job;
  logic push, pop, rd_valid, full, accept;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CARD_MODE:    cfg_nxt.card_mode    = cfg_data[0];
        CFG_READER_START: cfg_nxt.reader_start = cfg_data;
        CFG_CARD_START:   cfg_nxt.card_start   = cfg_data;
        CFG_CARD_END:     cfg_nxt.card_end     = cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.card_mode    <= 1'b0;
      cfg_r.reader_start <= READER_START_RST;
      cfg_r.card_start   <= CARD_START_RST;
      cfg_r.card_end     <= CARD_END_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  ife_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .accept      (accept),
    .data_bits   (in_data_bits),
    .bit_count   (in_bit_count),
    .frame_start (in_frame_start),
    .frame_end   (in_frame_end),
    .job         (wr_job),
    .push        (push)
  );

  ife_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_job   (wr_job),
    .pop      (pop),
    .rd_job   (rd_job),
    .rd_valid (rd_valid),
    .full     (full)
  );

  ife_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .rd_job           (rd_job),
    .rd_valid         (rd_valid),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_coded_byte   (out_coded_byte),
    .out_nibble_count (out_nibble_count),
    .out_last_out     (out_last_out)
  );

endmodule
